// ----- sv/hms_pkg.sv -----
// hms_pkg: shared types and constants for the 3x3 height map smoothing block
// no dependencies; used by hms_blend, hms_out_seq and heightmap_smooth_3x3
`timescale 1ns / 1ps

package hms_pkg;

  // coordinate and configuration widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAP_W_W    = 11;
  localparam int MAP_H_W    = 13;
  localparam int STR_W      = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_STRENGTH = 2'd2;

  // configuration reset values and limits
  localparam logic [MAP_W_W-1:0] MAP_WIDTH_RST      = 11'd256;
  localparam logic [MAP_H_W-1:0] MAP_HEIGHT_RST     = 13'd256;
  localparam logic [STR_W-1:0]   BLEND_STRENGTH_RST = 9'd128;
  localparam logic [STR_W-1:0]   STRENGTH_ONE       = 9'd256;
  localparam logic [MAP_H_W-1:0] MAP_HEIGHT_MAX     = 13'd4096;
  localparam logic [12:0]        MAP_DIM_MIN        = 13'd3;

  // result slots of one item, in emission order
  localparam int SLOT_A = 0;  // interior or border pixel one row, one column back
  localparam int SLOT_B = 1;  // last column of the row above
  localparam int SLOT_C = 2;  // last row, passed through
  localparam int SLOTS  = 3;

  // per-item control that travels with the data down the pipeline
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit_a;
    logic             interior;
    logic             emit_b;
    logic             emit_c;
    logic             done;
  } hms_ctrl_t;

endpackage

// ----- sv/hms_line_store.sv -----
// hms_line_store: two-row line store, one word per column holding both rows
// no package dependencies; instantiated by heightmap_smooth_3x3
`timescale 1ns / 1ps

module hms_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/hms_window.sv -----
// hms_window: last two columns of the 3x3 window and the nine-sample sum
// no package dependencies; instantiated by heightmap_smooth_3x3
`timescale 1ns / 1ps

module hms_window #(
  parameter int SB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  logic signed [SB-1:0] top,
  input  logic signed [SB-1:0] mid,
  input  logic signed [SB-1:0] bot,
  output logic signed [SB+3:0] sum9,
  output logic signed [SB-1:0] cur
);

  localparam int SUM_W = SB + 4;

  logic signed [SB-1:0] win_r   [6];
  logic signed [SB-1:0] win_nxt [6];

  // shift the newest column in, the previous one moves back
  always_comb begin
    win_nxt[0] = top;
    win_nxt[1] = mid;
    win_nxt[2] = bot;
    win_nxt[3] = win_r[0];
    win_nxt[4] = win_r[1];
    win_nxt[5] = win_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // neighborhood sum, current pixel is the middle of the previous column
  assign sum9 = SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot)
              + SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
              + SUM_W'(win_r[3]) + SUM_W'(win_r[4]) + SUM_W'(win_r[5]);
  assign cur  = win_r[1];

endmodule

// ----- sv/hms_blend.sv -----
// hms_blend: three-stage blend of the current pixel toward the 3x3 average
// depends on hms_pkg for the control struct; instantiated by heightmap_smooth_3x3
`timescale 1ns / 1ps

module hms_blend #(
  parameter int SB = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hms_pkg::hms_ctrl_t       in_ctrl,
  input  logic signed [SB+3:0]     in_sum9,
  input  logic signed [SB-1:0]     in_cur,
  input  logic signed [SB-1:0]     in_mid,
  input  logic signed [SB-1:0]     in_bot,
  input  logic [hms_pkg::STR_W-1:0] strength,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hms_pkg::hms_ctrl_t       out_ctrl,
  output logic signed [SB-1:0]     out_res_a,
  output logic signed [SB-1:0]     out_mid,
  output logic signed [SB-1:0]     out_bot
);

  localparam int SUM_W = SB + 4;
  localparam int DIF_W = SB + 5;
  localparam int PRD_W = DIF_W + hms_pkg::STR_W + 1;
  localparam int U_W   = SB + 8;
  localparam int V_W   = U_W + 1;

  // offset that keeps the quotient input positive: 9 * K, K = 2^(SB+4)
  localparam logic [U_W-1:0] K_VAL    = {4'b0001, {(SB + 4){1'b0}}};
  localparam logic [U_W-1:0] U_OFF    = K_VAL * U_W'(9);
  localparam logic [U_W:0]   U_POW    = {1'b1, {U_W{1'b0}}};
  localparam logic [U_W-1:0] M_RECIP  = U_W'(U_POW / (U_W + 1)'(9));
  localparam logic [U_W-1:0] NINE     = U_W'(9);
  localparam logic signed [V_W-1:0] S_MAX = $signed({{(V_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}});
  localparam logic signed [V_W-1:0] S_MIN = $signed({{(V_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}});

  // stage registers
  logic                   v1_r, v2_r, v3_r;
  logic                   v1_nxt, v2_nxt, v3_nxt;
  logic                   rdy1, rdy2, rdy3;
  hms_pkg::hms_ctrl_t     ctrl1_r, ctrl2_r, ctrl3_r;
  logic signed [SUM_W-1:0] sum1_r;
  logic signed [SB-1:0]   cur1_r, cur2_r, cur3_r;
  logic signed [SB-1:0]   mid1_r, mid2_r, mid3_r;
  logic signed [SB-1:0]   bot1_r, bot2_r, bot3_r;
  logic signed [PRD_W-1:0] prod2_r, prod2_nxt;
  logic [U_W-1:0]         u3_r, u3_nxt;
  logic [U_W-1:0]         qhi3_r, qhi3_nxt;

  logic signed [DIF_W-1:0] diff;
  logic signed [PRD_W-1:0] ysh;
  logic [2*U_W-1:0]       qm;
  logic [U_W-1:0]         nine_q;
  logic [U_W-1:0]         rem;
  logic [U_W-1:0]         q;
  logic signed [V_W-1:0]  delta;
  logic signed [V_W-1:0]  val_w;
  logic signed [SB-1:0]   val;

  // stall chain: a stage loads when it is empty or its content moves on
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 2 math: (sum9 - 9*cur) * strength
  assign diff      = DIF_W'(sum1_r) - ((DIF_W'(cur1_r) <<< 3) + DIF_W'(cur1_r));
  assign prod2_nxt = diff * $signed({1'b0, strength});

  // stage 3 math: floor by 256, shift positive, reciprocal multiply by 1/9
  assign ysh      = prod2_r >>> 8;
  assign u3_nxt   = U_W'(ysh) + U_OFF;
  assign qm       = (2 * U_W)'(u3_nxt) * (2 * U_W)'(M_RECIP);
  assign qhi3_nxt = qm[2*U_W-1:U_W];

  // output math: correct the quotient estimate, remove the offset, add to cur
  assign nine_q = U_W'({qhi3_r, 3'b000}) + qhi3_r;
  assign rem    = u3_r - nine_q;
  assign q      = qhi3_r + U_W'(rem >= NINE);
  assign delta  = $signed({1'b0, q}) - $signed({1'b0, K_VAL});
  assign val_w  = V_W'(cur3_r) + delta;

  always_comb begin
    if (val_w > S_MAX) begin
      val = SB'(S_MAX);
    end else if (val_w < S_MIN) begin
      val = SB'(S_MIN);
    end else begin
      val = SB'(val_w);
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy1) begin
      ctrl1_r <= in_ctrl;
      sum1_r  <= in_sum9;
      cur1_r  <= in_cur;
      mid1_r  <= in_mid;
      bot1_r  <= in_bot;
    end
    if (rdy2) begin
      ctrl2_r <= ctrl1_r;
      prod2_r <= prod2_nxt;
      cur2_r  <= cur1_r;
      mid2_r  <= mid1_r;
      bot2_r  <= bot1_r;
    end
    if (rdy3) begin
      ctrl3_r <= ctrl2_r;
      u3_r    <= u3_nxt;
      qhi3_r  <= qhi3_nxt;
      cur3_r  <= cur2_r;
      mid3_r  <= mid2_r;
      bot3_r  <= bot2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_ctrl  = ctrl3_r;
  assign out_res_a = ctrl3_r.interior ? val : cur3_r;
  assign out_mid   = mid3_r;
  assign out_bot   = bot3_r;

endmodule

// ----- sv/hms_out_seq.sv -----
// hms_out_seq: holds the up to three results of one item and sends them in order
// depends on hms_pkg for the control struct and slot codes
`timescale 1ns / 1ps

module hms_out_seq #(
  parameter int SB = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hms_pkg::hms_ctrl_t            in_ctrl,
  input  logic signed [SB-1:0]          in_res_a,
  input  logic signed [SB-1:0]          in_mid,
  input  logic signed [SB-1:0]          in_bot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hms_pkg::COL_W-1:0]     out_col,
  output logic [hms_pkg::ROW_W-1:0]     out_row,
  output logic signed [SB-1:0]          out_height,
  output logic                          out_last,
  output logic                          out_done
);

  logic [hms_pkg::SLOTS-1:0] pend_r, pend_nxt;
  logic [hms_pkg::SLOTS-1:0] sel;
  logic [hms_pkg::SLOTS-1:0] rest;
  hms_pkg::hms_ctrl_t        ctrl_r;
  logic signed [SB-1:0]      res_a_r, mid_r, bot_r;
  logic                      take;
  logic                      load;

  // lowest pending slot goes first
  assign sel  = pend_r & (~pend_r + 3'b001);
  assign rest = pend_r & ~sel;
  assign take = out_valid && out_ready;

  // a new item enters when the bundle is empty or its final result leaves
  assign in_ready = (pend_r == '0) || (take && (rest == '0));
  assign load     = in_valid && in_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt[hms_pkg::SLOT_A] = in_ctrl.emit_a;
      pend_nxt[hms_pkg::SLOT_B] = in_ctrl.emit_b;
      pend_nxt[hms_pkg::SLOT_C] = in_ctrl.emit_c;
    end else if (take) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r  <= in_ctrl;
      res_a_r <= in_res_a;
      mid_r   <= in_mid;
      bot_r   <= in_bot;
    end
  end

  // result fields of the selected slot
  always_comb begin
    out_done = 1'b0;
    if (sel[hms_pkg::SLOT_A]) begin
      out_col    = ctrl_r.col - 1'b1;
      out_row    = ctrl_r.row - 1'b1;
      out_height = res_a_r;
    end else if (sel[hms_pkg::SLOT_B]) begin
      out_col    = ctrl_r.col;
      out_row    = ctrl_r.row - 1'b1;
      out_height = mid_r;
    end else begin
      out_col    = ctrl_r.col;
      out_row    = ctrl_r.row;
      out_height = bot_r;
      out_done   = ctrl_r.done;
    end
  end

  assign out_valid = (pend_r != '0);
  assign out_last  = (rest == '0);

endmodule

// ----- sv/heightmap_smooth_3x3.sv -----
// heightmap_smooth_3x3: one 3x3 box-blend smoothing pass over a raster height map
// depends on hms_pkg, hms_line_store, hms_window, hms_blend and hms_out_seq
`timescale 1ns / 1ps

//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_ready, in_height_sample            | in
//  result   | out_valid, out_ready, out_col, out_row,         | out
//           | out_height, out_last_of_run, out_frame_done     |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
//  In steady state one item per clock is accepted while the result side keeps
//  up; an accepted item passes the first stage, the blend stages and the
//  sequencer register. The output sequencer sends one result per clock while
//  out_ready is high, so an item with up to three results sends them in turn.
//  Stalls on the result side back up through the pipeline stage by stage;
//  empty stages still fill. Config writes are taken every cycle.
//  Reset is synchronous, active low; the line store is not cleared.

module heightmap_smooth_3x3 #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_height_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hms_pkg::COL_W-1:0]          out_col,
  output logic [hms_pkg::ROW_W-1:0]          out_row,
  output logic signed [SAMPLE_BITS-1:0]      out_height,
  output logic                               out_last_of_run,
  output logic                               out_frame_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [12:0] MAXW_M1 = 13'(MAX_WIDTH - 1);

  // configuration registers
  logic [hms_pkg::MAP_W_W-1:0] map_width_r;
  logic [hms_pkg::MAP_H_W-1:0] map_height_r;
  logic [hms_pkg::STR_W-1:0]   blend_strength_r;
  logic [hms_pkg::STR_W-1:0]   strength;

  // position counters
  logic [hms_pkg::COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [hms_pkg::ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [12:0]               wm1, hm1, wext;
  logic                      last_col, last_row;

  // first stage: sample, line store read data, control
  logic                  v1_r, v1_nxt;
  logic signed [SB-1:0]  bot1_r;
  hms_pkg::hms_ctrl_t    ctrl1_r, ctrl1_nxt;
  logic                  in_acc, adv1;
  logic [2*SB-1:0]       ls_rd;
  logic signed [SB-1:0]  top1, mid1;
  logic signed [SB+3:0]  sum9;
  logic signed [SB-1:0]  cur;

  // blend to output sequencer
  logic                  bl_in_ready;
  logic                  bl_valid, sq_ready;
  hms_pkg::hms_ctrl_t    bl_ctrl;
  logic signed [SB-1:0]  bl_res_a, bl_mid, bl_bot;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r      <= hms_pkg::MAP_WIDTH_RST;
      map_height_r     <= hms_pkg::MAP_HEIGHT_RST;
      blend_strength_r <= hms_pkg::BLEND_STRENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        hms_pkg::CFG_MAP_WIDTH:      map_width_r      <= cfg_data[hms_pkg::MAP_W_W-1:0];
        hms_pkg::CFG_MAP_HEIGHT:     map_height_r     <= cfg_data[hms_pkg::MAP_H_W-1:0];
        hms_pkg::CFG_BLEND_STRENGTH: blend_strength_r <= cfg_data[hms_pkg::STR_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated strength and last column / row indexes
  assign strength = (blend_strength_r > hms_pkg::STRENGTH_ONE) ? hms_pkg::STRENGTH_ONE
                                                               : blend_strength_r;
  assign wext     = 13'(map_width_r);

  always_comb begin
    if (wext < hms_pkg::MAP_DIM_MIN) begin
      wm1 = hms_pkg::MAP_DIM_MIN - 1'b1;
    end else if (wext > MAXW_M1) begin
      wm1 = MAXW_M1;
    end else begin
      wm1 = wext - 1'b1;
    end
    if (map_height_r < hms_pkg::MAP_DIM_MIN) begin
      hm1 = hms_pkg::MAP_DIM_MIN - 1'b1;
    end else if (map_height_r > hms_pkg::MAP_HEIGHT_MAX) begin
      hm1 = hms_pkg::MAP_HEIGHT_MAX - 1'b1;
    end else begin
      hm1 = map_height_r - 1'b1;
    end
  end

  assign last_col = 13'(col_cnt_r) >= wm1;
  assign last_row = 13'(row_cnt_r) >= hm1;

  // control for the accepted item
  always_comb begin
    ctrl1_nxt.col      = col_cnt_r;
    ctrl1_nxt.row      = row_cnt_r;
    ctrl1_nxt.emit_a   = (row_cnt_r != '0) && (col_cnt_r != '0);
    ctrl1_nxt.interior = (row_cnt_r >= 12'd2) && (col_cnt_r >= 10'd2);
    ctrl1_nxt.emit_b   = (row_cnt_r != '0) && last_col;
    ctrl1_nxt.emit_c   = last_row;
    ctrl1_nxt.done     = last_col;
  end

  // raster position advance
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  // first stage handshake
  assign in_ready = !v1_r || bl_in_ready;
  assign in_acc   = in_valid && in_ready;
  assign adv1     = v1_r && bl_in_ready;
  assign v1_nxt   = in_ready ? in_valid : v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      v1_r      <= v1_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bot1_r  <= in_height_sample;
      ctrl1_r <= ctrl1_nxt;
    end
  end

  // line store word: upper half two rows back, lower half one row back
  hms_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * SB)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (AW'(col_cnt_r)),
    .rd_data (ls_rd),
    .wr_en   (adv1),
    .wr_addr (AW'(ctrl1_r.col)),
    .wr_data ({mid1, bot1_r})
  );

  assign top1 = ls_rd[2*SB-1:SB];
  assign mid1 = ls_rd[SB-1:0];

  // window columns and neighborhood sum
  hms_window #(
    .SB (SB)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (adv1),
    .top      (top1),
    .mid      (mid1),
    .bot      (bot1_r),
    .sum9     (sum9),
    .cur      (cur)
  );

  // blend arithmetic
  hms_blend #(
    .SB (SB)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_ready  (bl_in_ready),
    .in_ctrl   (ctrl1_r),
    .in_sum9   (sum9),
    .in_cur    (cur),
    .in_mid    (mid1),
    .in_bot    (bot1_r),
    .strength  (strength),
    .out_valid (bl_valid),
    .out_ready (sq_ready),
    .out_ctrl  (bl_ctrl),
    .out_res_a (bl_res_a),
    .out_mid   (bl_mid),
    .out_bot   (bl_bot)
  );

  // result sequencing
  hms_out_seq #(
    .SB (SB)
  ) u_out_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bl_valid),
    .in_ready   (sq_ready),
    .in_ctrl    (bl_ctrl),
    .in_res_a   (bl_res_a),
    .in_mid     (bl_mid),
    .in_bot     (bl_bot),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_col    (out_col),
    .out_row    (out_row),
    .out_height (out_height),
    .out_last   (out_last_of_run),
    .out_done   (out_frame_done)
  );

endmodule

// ----- tb/tb_heightmap_smooth_3x3.sv -----
// tb_heightmap_smooth_3x3: self-checking bench for the 3x3 height map smoothing block
// depends on hms_pkg and heightmap_smooth_3x3; predicts every result in a scoreboard class
`timescale 1ns / 1ps

module tb_heightmap_smooth_3x3;
  import hms_pkg::*;

  localparam int SAMPLE_BITS   = 16;
  localparam int LINE_DEPTH    = 1024;
  localparam int BLEND_DEN     = 2304;
  localparam int MAX_GAP       = 10;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 5000;
  localparam int RANDOM_ITEMS  = 460;

  // index with no register behind it, written once to see it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

  // 3x3 maps for the corner cases
  localparam logic signed [SAMPLE_BITS-1:0] EXTREME_FRAME [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh0100, 16'shFF00, 16'sh8000, 16'sh7FFF};
  localparam logic signed [SAMPLE_BITS-1:0] CHECKER_FRAME [9] = '{
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
    16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};

  typedef struct {
    logic [COL_W-1:0]             col;
    logic [ROW_W-1:0]             row;
    logic signed [SAMPLE_BITS-1:0] height;
    logic                          last;
    logic                          done;
  } pixel_t;

  // mirror of the smoothing pass plus the queue of pixels still to come
  class smoothed_pixel_board;
    logic [MAP_W_W-1:0] width_q;
    logic [MAP_H_W-1:0] height_q;
    logic [STR_W-1:0]   strength_q;
    int                 line_mem [2 * LINE_DEPTH];
    int                 win [6];
    logic [COL_W-1:0]   col_q;
    logic [ROW_W-1:0]   row_q;
    pixel_t             pending_pixels [$];
    int                 errors;

    function new();
      width_q    = MAP_WIDTH_RST;
      height_q   = MAP_HEIGHT_RST;
      strength_q = BLEND_STRENGTH_RST;
      foreach (line_mem[i]) line_mem[i] = 0;
      foreach (win[i]) win[i] = 0;
      col_q  = '0;
      row_q  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAP_WIDTH:      width_q = data[MAP_W_W-1:0];
        CFG_MAP_HEIGHT:     height_q = data[MAP_H_W-1:0];
        CFG_BLEND_STRENGTH: strength_q = data[STR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function bit at_origin();
      return col_q == 0 && row_q == 0;
    endfunction

    function void add_pixel(int col, int row, int height, bit done);
      pixel_t p;
      p.col    = COL_W'(col);
      p.row    = ROW_W'(row);
      p.height = SAMPLE_BITS'(height);
      p.last   = 1'b0;
      p.done   = done;
      pending_pixels.push_back(p);
    endfunction

    // one accepted item: update line stores and window, queue its pixels
    function void take_sample(logic signed [SAMPLE_BITS-1:0] sample);
      int     w, h, str, c, r, top, mid, bot, cur, val, acc, before_n;
      longint num, quo;
      bit     lastc, lastr;
      w = width_q;
      h = height_q;
      str = strength_q;
      if (w < 3) w = 3;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h < 3) h = 3;
      if (h > int'(MAP_HEIGHT_MAX)) h = MAP_HEIGHT_MAX;
      if (str > int'(STRENGTH_ONE)) str = STRENGTH_ONE;
      c = col_q;
      r = row_q;
      top = line_mem[LINE_DEPTH + c];
      mid = line_mem[c];
      bot = sample;
      line_mem[LINE_DEPTH + c] = mid;
      line_mem[c] = bot;
      lastc = c >= w - 1;
      lastr = r >= h - 1;
      before_n = pending_pixels.size();

      // pixel one row up and one column back
      if (r >= 1 && c >= 1) begin
        cur = win[1];
        val = cur;
        if (r >= 2 && c >= 2) begin
          acc = top + mid + bot;
          foreach (win[i]) acc += win[i];
          num = longint'(acc - 9 * cur) * str;
          quo = num / BLEND_DEN;
          if (num % BLEND_DEN != 0 && num < 0) quo--;
          val = cur + int'(quo);
          if (val > int'(SAMPLE_MAX)) val = SAMPLE_MAX;
          if (val < int'(SAMPLE_MIN)) val = SAMPLE_MIN;
        end
        add_pixel(c - 1, r - 1, val, 1'b0);
      end
      // right border of the row above, then the bottom row passes through
      if (r >= 1 && lastc) add_pixel(c, r - 1, mid, 1'b0);
      if (lastr) add_pixel(c, r, bot, lastc);
      if (pending_pixels.size() > before_n) pending_pixels[$].last = 1'b1;

      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = top;
      win[1] = mid;
      win[2] = bot;

      if (lastc) begin
        col_q = '0;
        row_q = lastr ? '0 : ROW_W'(r + 1);
      end else begin
        col_q = COL_W'(c + 1);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: out_col %0d out_row %0d out_height %0d",
               got.col, got.row, got.height);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.col !== want.col) begin
        $error("out_col expected %0d actual %0d", want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("out_row expected %0d actual %0d", want.row, got.row);
        errors++;
      end
      if (got.height !== want.height) begin
        $error("out_height expected %0d actual %0d", want.height, got.height);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last_of_run expected %0b actual %0b", want.last, got.last);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("out_frame_done expected %0b actual %0b", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_height_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic [COL_W-1:0]              out_col;
  logic [ROW_W-1:0]              out_row;
  logic signed [SAMPLE_BITS-1:0] out_height;
  logic                          out_last_of_run;
  logic                          out_frame_done;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;

  smoothed_pixel_board pixels;
  bit                  send_burst;

  heightmap_smooth_3x3 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_height_sample (in_height_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_height       (out_height),
    .out_last_of_run  (out_last_of_run),
    .out_frame_done   (out_frame_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly full-range noise, with extremes and small values mixed in
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: begin
        v = $urandom_range(0, 64) - 32;
        return SAMPLE_BITS'(v);
      end
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_width();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1: return CFG_DATA_W'($urandom_range(13, 64));
      default: return CFG_DATA_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom_range(0, 2));
    return CFG_DATA_W'($urandom_range(3, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_strength();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'(STRENGTH_ONE);
      1: return CFG_DATA_W'($urandom_range(257, 511));
      2: return '0;
      3: return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(0, 256));
    endcase
  endfunction

  // one item on the input channel after a random gap; valid stays up for a follower
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_height_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels.take_sample(sample);
  endtask

  // stream until the map wraps back to pixel (0, 0)
  task automatic send_frame();
    do send_sample(rand_sample()); while (!pixels.at_origin());
  endtask

  // hold the input off until all results are in and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back register writes, optionally led by the unused index
  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] s, input bit with_spare);
    logic [CFG_IDX_W-1:0]  idx_seq [4];
    logic [CFG_DATA_W-1:0] data_seq [4];
    idx_seq  = '{CFG_SPARE, CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_BLEND_STRENGTH};
    data_seq = '{'1, w, h, s};
    for (int i = with_spare ? 0 : 1; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_seq[i];
      cfg_data  <= data_seq[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      pixels.write_reg(idx_seq[i], data_seq[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall before each item, with stretches of none
  initial begin : result_sink
    int     stall;
    bit     burst;
    pixel_t got;
    out_ready <= 1'b0;
    burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.col    = out_col;
      got.row    = out_row;
      got.height = out_height;
      got.last   = out_last_of_run;
      got.done   = out_frame_done;
      pixels.check_pixel(got);
    end
  end

  // ends a hung run: too many cycles with no handshake on any channel
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int k, cut, random_sent;
    pixels     = new();
    send_burst = 1'b0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_height_sample <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_MAP_WIDTH;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width and strength over three rows, then the height drops
    // below the row counter so the fourth row closes the map
    repeat (3 * 256) send_sample(rand_sample());
    settle();
    configure(13'd256, 13'd0, 13'd128, 1'b1);
    send_frame();

    // widest map, all-ones data: width and strength saturate
    settle();
    configure('1, 13'd3, '1, 1'b0);
    send_frame();

    // smallest maps: extremes with no blend, checkerboard at full average
    settle();
    configure(13'd0, 13'd3, 13'd0, 1'b0);
    foreach (EXTREME_FRAME[i]) send_sample(EXTREME_FRAME[i]);
    settle();
    configure(13'd3, 13'd2, 13'(STRENGTH_ONE), 1'b0);
    foreach (CHECKER_FRAME[i]) send_sample(CHECKER_FRAME[i]);

    // random maps, some resized part way through, with the odd full drain
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      configure(rand_width(), rand_height(), rand_strength(), 1'b0);
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0;
      k = 0;
      do begin
        send_sample(rand_sample());
        k++;
        if (k == cut) begin
          settle();
          configure(rand_width(), rand_height(), rand_strength(), 1'b0);
        end else if ($urandom_range(0, 99) == 0) begin
          settle();
        end
      end while (!pixels.at_origin());
      random_sent += k;
    end

    // tallest map, narrowest width
    settle();
    configure(13'd3, '1, rand_strength(), 1'b0);
    send_frame();

    settle();
    if (pixels.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
